// ===== sv/uofc_pkg.sv =====
package uofc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65535;

    localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam int ETH_TYPE_OFS  = 12;
    localparam int COOKED_EXTRA  = 2;
    localparam int ETH_TYPE_LEN  = 2;
    localparam int VLAN_TAG_LEN  = 4;
    localparam int LINK_HDR_MIN  = 14;
    localparam int IP_HDR_MIN    = 20;
    localparam int UDP_HDR_LEN   = 8;
    localparam int IP_PROTO_OFS  = 9;
    localparam int IP_SRC_OFS    = 12;
    localparam int IP_DST_OFS    = 16;
    localparam int UDP_DPORT_OFS = 2;

    localparam int  PADDR_W       = 3;
    localparam logic REG_LINK_TYPE = 1'b0;

    typedef enum logic [2:0] {
        ST_UDP_OK     = 3'd0,
        ST_LINK_SHORT = 3'd1,
        ST_NOT_IPV4   = 3'd2,
        ST_IP_SHORT   = 3'd3,
        ST_NOT_UDP    = 3'd4,
        ST_UDP_SHORT  = 3'd5
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] udp_count;
    } t_result;

endpackage

// ===== sv/udp_over_ipv4_frame_classifier.sv =====
// Byte-stream classifier for UDP over IPv4. One frame byte is taken per clock, with
// i_last_byte on the final byte; one result request follows each final byte, carrying a
// status code, the MAC addresses, IP addresses and UDP ports captured by their offset in
// the frame (zero where the frame ended early), and a saturating count of frames with status UDP_OK.
// link_type (register 0) selects Ethernet framing or cooked capture, which moves the
// ethertype two bytes later; one 802.1Q tag is skipped. A byte passes through an input
// register and a single step of capture and check logic into a result register backed by
// a skid register, so a new byte is taken every cycle and the result of a final byte is
// registered in that pair; only a final byte that finds the skid register occupied waits.
module udp_over_ipv4_frame_classifier #(
    parameter int MAX_FRAME_BYTES = uofc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uofc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [47:0]                  o_dst_mac,
    output logic [47:0]                  o_src_mac,
    output logic [31:0]                  o_src_ip,
    output logic [31:0]                  o_dst_ip,
    output logic [15:0]                  o_src_port,
    output logic [15:0]                  o_dst_port,
    output logic [31:0]                  o_udp_count
);
    import uofc_pkg::*;

    logic        r_link_type;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic        r_skid_valid;
    t_result     r_out;
    t_result     r_skid;

    logic [15:0] r_pos;
    logic        r_vlan;
    logic [15:0] r_ethertype;
    logic [3:0]  r_ihl;
    logic [7:0]  r_protocol;
    logic [47:0] r_dst_mac;
    logic [47:0] r_src_mac;
    logic [31:0] r_src_ip;
    logic [31:0] r_dst_ip;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic [31:0] r_total;

    logic [15:0] n_pos;
    logic        n_vlan;
    logic [15:0] n_ethertype;
    logic [3:0]  n_ihl;
    logic [7:0]  n_protocol;
    logic [47:0] n_dst_mac;
    logic [47:0] n_src_mac;
    logic [31:0] n_src_ip;
    logic [31:0] n_dst_ip;
    logic [15:0] n_src_port;
    logic [15:0] n_dst_port;
    logic [31:0] n_total;
    t_status     n_status;
    t_result     n_result;

    logic [4:0]  eth_ofs;
    logic [4:0]  ip_ofs;
    logic [6:0]  udp_ofs;
    logic [15:0] off_ip;
    logic [15:0] off_udp;
    logic [15:0] frame_len;
    logic        proc_en;
    logic        res_en;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign prdata  = {31'd0, r_link_type};
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign proc_en = r_in_valid && !(r_in_last && r_skid_valid);
    assign res_en  = proc_en && r_in_last;
    assign o_stall = r_in_valid && !proc_en;

    always_comb begin
        n_dst_mac   = r_dst_mac;
        n_src_mac   = r_src_mac;
        n_ethertype = r_ethertype;
        n_vlan      = r_vlan;
        n_ihl       = r_ihl;
        n_protocol  = r_protocol;
        n_src_ip    = r_src_ip;
        n_dst_ip    = r_dst_ip;
        n_src_port  = r_src_port;
        n_dst_port  = r_dst_port;

        eth_ofs = r_link_type ? 5'(ETH_TYPE_OFS + COOKED_EXTRA) : 5'(ETH_TYPE_OFS);

        for (int k = 0; k < 6; k++) begin
            if (r_pos == 16'(k)) begin
                n_dst_mac[8*(5-k) +: 8] = r_dst_mac[8*(5-k) +: 8] | r_in_byte;
            end
            if (r_pos == 16'(k + 6)) begin
                n_src_mac[8*(5-k) +: 8] = r_src_mac[8*(5-k) +: 8] | r_in_byte;
            end
        end

        if (r_pos == 16'(eth_ofs)) begin
            n_ethertype = {r_in_byte, 8'd0};
        end else if (r_pos == 16'(eth_ofs) + 16'd1) begin
            n_ethertype = {r_ethertype[15:8], r_ethertype[7:0] | r_in_byte};
            n_vlan      = (n_ethertype == ETHERTYPE_VLAN);
        end else if (r_vlan && r_pos == 16'(eth_ofs) + 16'(VLAN_TAG_LEN)) begin
            n_ethertype = {r_in_byte, 8'd0};
        end else if (r_vlan && r_pos == 16'(eth_ofs) + 16'(VLAN_TAG_LEN + 1)) begin
            n_ethertype = {r_ethertype[15:8], r_ethertype[7:0] | r_in_byte};
        end

        ip_ofs  = eth_ofs + 5'(ETH_TYPE_LEN) + (n_vlan ? 5'(VLAN_TAG_LEN) : 5'd0);
        off_ip  = r_pos - 16'(ip_ofs);
        udp_ofs = 7'(ip_ofs);
        off_udp = 16'd0;

        if (r_pos >= 16'(ip_ofs)) begin
            if (off_ip == 16'd0) begin
                n_ihl = r_in_byte[3:0];
            end else if (off_ip == 16'(IP_PROTO_OFS)) begin
                n_protocol = r_in_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (off_ip == 16'(IP_SRC_OFS + k)) begin
                    n_src_ip[8*(3-k) +: 8] = r_src_ip[8*(3-k) +: 8] | r_in_byte;
                end
                if (off_ip == 16'(IP_DST_OFS + k)) begin
                    n_dst_ip[8*(3-k) +: 8] = r_dst_ip[8*(3-k) +: 8] | r_in_byte;
                end
            end
            udp_ofs = 7'(ip_ofs) + {1'b0, n_ihl, 2'b00};
            off_udp = r_pos - 16'(udp_ofs);
            if (r_pos >= 16'(udp_ofs)) begin
                for (int k = 0; k < 2; k++) begin
                    if (off_udp == 16'(k)) begin
                        n_src_port[8*(1-k) +: 8] = r_src_port[8*(1-k) +: 8] | r_in_byte;
                    end
                    if (off_udp == 16'(UDP_DPORT_OFS + k)) begin
                        n_dst_port[8*(1-k) +: 8] = r_dst_port[8*(1-k) +: 8] | r_in_byte;
                    end
                end
            end
        end else begin
            udp_ofs = 7'(ip_ofs) + {1'b0, n_ihl, 2'b00};
        end

        if (r_pos < 16'(MAX_FRAME_BYTES)) begin
            n_pos     = r_pos + 16'd1;
            frame_len = r_pos + 16'd1;
        end else begin
            n_pos     = r_pos;
            frame_len = 16'(MAX_FRAME_BYTES);
        end

        n_total = r_total;
        if (frame_len < 16'(LINK_HDR_MIN)) begin
            n_status = ST_LINK_SHORT;
        end else if (n_ethertype != ETHERTYPE_IPV4) begin
            n_status = ST_NOT_IPV4;
        end else if (frame_len < 16'(ip_ofs) + 16'(IP_HDR_MIN)) begin
            n_status = ST_IP_SHORT;
        end else if (n_protocol != PROTO_UDP) begin
            n_status = ST_NOT_UDP;
        end else if (frame_len < 16'(udp_ofs) + 16'(UDP_HDR_LEN)) begin
            n_status = ST_UDP_SHORT;
        end else begin
            n_status = ST_UDP_OK;
            if (r_total != '1) begin
                n_total = r_total + 32'd1;
            end
        end

        n_result.status    = n_status;
        n_result.dst_mac   = n_dst_mac;
        n_result.src_mac   = n_src_mac;
        n_result.src_ip    = n_src_ip;
        n_result.dst_ip    = n_dst_ip;
        n_result.src_port  = n_src_port;
        n_result.dst_port  = n_dst_port;
        n_result.udp_count = n_total;
    end

    // control and per-frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type  <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_pos        <= '0;
            r_vlan       <= 1'b0;
            r_ethertype  <= '0;
            r_ihl        <= '0;
            r_protocol   <= '0;
            r_dst_mac    <= '0;
            r_src_mac    <= '0;
            r_src_ip     <= '0;
            r_dst_ip     <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
            r_total      <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_LINK_TYPE) begin
                r_link_type <= pwdata[0];
            end

            if (!o_stall) begin
                r_in_valid <= i_valid;
            end

            if (proc_en) begin
                if (r_in_last) begin
                    r_pos       <= '0;
                    r_vlan      <= 1'b0;
                    r_ethertype <= '0;
                    r_ihl       <= '0;
                    r_protocol  <= '0;
                    r_dst_mac   <= '0;
                    r_src_mac   <= '0;
                    r_src_ip    <= '0;
                    r_dst_ip    <= '0;
                    r_src_port  <= '0;
                    r_dst_port  <= '0;
                    r_total     <= n_total;
                end else begin
                    r_pos       <= n_pos;
                    r_vlan      <= n_vlan;
                    r_ethertype <= n_ethertype;
                    r_ihl       <= n_ihl;
                    r_protocol  <= n_protocol;
                    r_dst_mac   <= n_dst_mac;
                    r_src_mac   <= n_src_mac;
                    r_src_ip    <= n_src_ip;
                    r_dst_ip    <= n_dst_ip;
                    r_src_port  <= n_src_port;
                    r_dst_port  <= n_dst_port;
                end
            end

            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_en;
                end
            end else if (res_en) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_en) begin
                r_out <= n_result;
            end
        end else if (res_en) begin
            r_skid <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_dst_mac   = r_out.dst_mac;
    assign o_src_mac   = r_out.src_mac;
    assign o_src_ip    = r_out.src_ip;
    assign o_dst_ip    = r_out.dst_ip;
    assign o_src_port  = r_out.src_port;
    assign o_dst_port  = r_out.dst_port;
    assign o_udp_count = r_out.udp_count;

endmodule
